### sv/wavhp_pkg.sv
// Shared types, constants and helpers of the WAV header parser.
`timescale 1ns / 1ps
`default_nettype none

package wavhp_pkg;

  // Bytes of the file that the parser looks at; offsets beyond it saturate.
  localparam int WINDOW_BYTES = 2048;
  localparam int OFFS_W       = $clog2(WINDOW_BYTES + 1);
  localparam int POS_W        = $clog2(WINDOW_BYTES);

  localparam int LIMIT_W       = 11;
  localparam int LIMIT_RESET   = 1792;
  localparam int START_W       = 12;
  localparam int END_W         = 33;

  localparam logic [2:0] LAYOUT_16_MONO   = 3'd0;
  localparam logic [2:0] LAYOUT_16_STEREO = 3'd1;
  localparam logic [2:0] LAYOUT_24_MONO   = 3'd2;
  localparam logic [2:0] LAYOUT_24_STEREO = 3'd3;
  localparam logic [2:0] LAYOUT_INVALID   = 3'd4;

  // Chunk IDs as they sit in a little-endian 32-bit word.
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [7:0] SIG_RIFF [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
  localparam logic [7:0] SIG_WAVE [4] = '{8'h57, 8'h41, 8'h56, 8'h45};

  localparam logic [15:0] FMT_TAG_PCM  = 16'd1;
  localparam logic [31:0] FMT_MIN_SIZE = 32'd16;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       layout_code;
    logic [15:0]      channel_count;
    logic [15:0]      sample_bits;
    logic [31:0]      rate_hz;
    logic [START_W-1:0] data_start;
    logic [END_W-1:0]   data_end;
  } out_item_t;

  function automatic logic [2:0] layout_of(input logic [15:0] bits, input logic [15:0] chans);
    logic [2:0] code;
    code = LAYOUT_INVALID;
    if (bits == 16'd16 && chans == 16'd1) code = LAYOUT_16_MONO;
    if (bits == 16'd16 && chans == 16'd2) code = LAYOUT_16_STEREO;
    if (bits == 16'd24 && chans == 16'd1) code = LAYOUT_24_MONO;
    if (bits == 16'd24 && chans == 16'd2) code = LAYOUT_24_STEREO;
    return code;
  endfunction

endpackage

`default_nettype wire

### sv/wavhp_core.sv
// Per-byte parse logic: header signature check, chunk walk and fmt field capture.
`timescale 1ns / 1ps
`default_nettype none

module wavhp_core (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    step_i,
  input  wire wavhp_pkg::in_item_t     item_i,
  input  wire logic [wavhp_pkg::LIMIT_W-1:0] search_limit_i,
  output logic                         res_valid_o,
  output wavhp_pkg::out_item_t         res_o
);
  import wavhp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEAD,
    PH_SEEK,
    PH_CHUNK,
    PH_DONE
  } phase_e;

  localparam logic [OFFS_W-1:0] REL_ID_END   = OFFS_W'(3);
  localparam logic [OFFS_W-1:0] REL_SIZE_END = OFFS_W'(7);
  localparam logic [OFFS_W-1:0] REL_TAG_END  = OFFS_W'(9);
  localparam logic [OFFS_W-1:0] REL_CH_END   = OFFS_W'(11);
  localparam logic [OFFS_W-1:0] REL_RATE_END = OFFS_W'(15);
  localparam logic [OFFS_W-1:0] REL_BITS_END = OFFS_W'(23);
  localparam logic [END_W-1:0]  GOTO_MAX     = END_W'(WINDOW_BYTES - 8);

  phase_e             phase_q, phase_d;
  logic [OFFS_W-1:0]  offset_q, offset_d;
  logic [POS_W-1:0]   target_q, target_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [31:0]        size_q, size_d;
  logic [31:0]        shift_q, shift_d;
  logic [15:0]        chans_q, chans_d;
  logic [15:0]        bits_q, bits_d;
  logic [31:0]        rate_q, rate_d;
  logic               fmt_seen_q, fmt_seen_d;
  logic               tag_hit_q, tag_hit_d;

  // State as seen by this byte: a file start clears everything first.
  logic               start;
  logic               active;
  phase_e             eff_phase;
  logic [OFFS_W-1:0]  cur;
  logic [POS_W-1:0]   eff_target, eff_pos;
  logic [31:0]        eff_size, eff_shift, eff_rate;
  logic [15:0]        eff_chans, eff_bits;
  logic               eff_fmt, eff_tag;

  logic               enter, in_chunk;
  logic [POS_W-1:0]   pos;
  logic [7:0]         b;
  logic [31:0]        shift_new;
  logic [OFFS_W-1:0]  rel;
  logic [31:0]        size_sel;
  logic [END_W-1:0]   next_sum;
  logic [END_W-1:0]   goto_dst;
  logic               fail, emit, go;

  assign b      = item_i.header_byte;
  assign start  = item_i.file_start;
  assign active = start || phase_q == PH_HEAD || phase_q == PH_SEEK || phase_q == PH_CHUNK;

  assign eff_phase  = start ? PH_HEAD : phase_q;
  assign cur        = start ? '0 : offset_q;
  assign eff_target = start ? '0 : target_q;
  assign eff_pos    = start ? '0 : pos_q;
  assign eff_size   = start ? '0 : size_q;
  assign eff_shift  = start ? '0 : shift_q;
  assign eff_rate   = start ? '0 : rate_q;
  assign eff_chans  = start ? '0 : chans_q;
  assign eff_bits   = start ? '0 : bits_q;
  assign eff_fmt    = start ? 1'b0 : fmt_seen_q;
  assign eff_tag    = start ? 1'b0 : tag_hit_q;

  assign enter     = eff_phase == PH_SEEK && cur == OFFS_W'(eff_target);
  assign pos       = enter ? cur[POS_W-1:0] : eff_pos;
  assign in_chunk  = eff_phase == PH_CHUNK || enter;
  assign shift_new = {b, eff_shift[31:8]};
  assign rel       = cur - OFFS_W'(pos);
  assign size_sel  = (rel == REL_SIZE_END) ? shift_new : eff_size;
  assign next_sum  = END_W'(size_sel) + END_W'(pos) + END_W'(8);
  assign goto_dst  = (eff_phase == PH_HEAD) ? END_W'(12) : next_sum;

  always_comb begin
    phase_d    = phase_q;
    offset_d   = offset_q;
    target_d   = target_q;
    pos_d      = pos_q;
    size_d     = size_q;
    shift_d    = shift_q;
    chans_d    = chans_q;
    bits_d     = bits_q;
    rate_d     = rate_q;
    fmt_seen_d = fmt_seen_q;
    tag_hit_d  = tag_hit_q;
    fail       = 1'b0;
    emit       = 1'b0;
    go         = 1'b0;
    if (step_i && active) begin
      phase_d    = enter ? PH_CHUNK : eff_phase;
      offset_d   = (cur < OFFS_W'(WINDOW_BYTES)) ? cur + OFFS_W'(1) : cur;
      target_d   = eff_target;
      pos_d      = pos;
      size_d     = eff_size;
      shift_d    = in_chunk ? shift_new : eff_shift;
      chans_d    = eff_chans;
      bits_d     = eff_bits;
      rate_d     = eff_rate;
      fmt_seen_d = eff_fmt;
      tag_hit_d  = eff_tag;
      if (eff_phase == PH_HEAD) begin
        if (cur < OFFS_W'(4)) begin
          fail = b != SIG_RIFF[cur[1:0]];
        end else if (cur >= OFFS_W'(8) && cur < OFFS_W'(12)) begin
          if (b != SIG_WAVE[cur[1:0]]) fail = 1'b1;
          else if (cur == OFFS_W'(11)) go = 1'b1;
        end
      end else if (in_chunk) begin
        unique case (rel)
          REL_ID_END: begin
            tag_hit_d = shift_new == (eff_fmt ? TAG_DATA : TAG_FMT);
            if (!tag_hit_d && 32'(pos) > 32'(search_limit_i)) fail = 1'b1;
          end
          REL_SIZE_END: begin
            size_d = shift_new;
            if (!eff_tag) go = 1'b1;
            else if (eff_fmt) emit = 1'b1;
            else if (shift_new < FMT_MIN_SIZE) fail = 1'b1;
          end
          REL_TAG_END: begin
            if (shift_new[31:16] != FMT_TAG_PCM) fail = 1'b1;
          end
          REL_CH_END:   chans_d = shift_new[31:16];
          REL_RATE_END: rate_d  = shift_new;
          REL_BITS_END: begin
            bits_d     = shift_new[31:16];
            fmt_seen_d = 1'b1;
            go         = 1'b1;
          end
          default: ;
        endcase
      end
      // A jump whose next chunk header would not fit in the window fails.
      if (go) begin
        if (goto_dst > GOTO_MAX) begin
          fail = 1'b1;
        end else begin
          target_d = goto_dst[POS_W-1:0];
          phase_d  = PH_SEEK;
        end
      end
      if (fail || emit) phase_d = PH_DONE;
    end
  end

  always_comb begin
    res_valid_o         = step_i && active && (fail || emit);
    res_o.layout_code   = fail ? LAYOUT_INVALID : layout_of(bits_d, chans_d);
    res_o.channel_count = chans_d;
    res_o.sample_bits   = bits_d;
    res_o.rate_hz       = rate_d;
    res_o.data_start    = fail ? '0 : START_W'(32'(pos) + 32'd8);
    res_o.data_end      = fail ? '0 : next_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      offset_q   <= '0;
      fmt_seen_q <= 1'b0;
      tag_hit_q  <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      offset_q   <= offset_d;
      fmt_seen_q <= fmt_seen_d;
      tag_hit_q  <= tag_hit_d;
    end
  end

  // These are cleared by every file start before they are used.
  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    pos_q    <= pos_d;
    size_q   <= size_d;
    shift_q  <= shift_d;
    chans_q  <= chans_d;
    bits_q   <= bits_d;
    rate_q   <= rate_d;
  end

endmodule

`default_nettype wire

### sv/wavhp_out_buf.sv
// Result register with a skid entry behind it.
`timescale 1ns / 1ps
`default_nettype none

module wavhp_out_buf (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire wavhp_pkg::out_item_t push_data_i,
  output logic                      full_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output wavhp_pkg::out_item_t      out_data_o
);
  import wavhp_pkg::*;

  logic      main_vld_q, main_vld_d;
  logic      skid_vld_q, skid_vld_d;
  out_item_t main_q, main_d;
  out_item_t skid_q, skid_d;
  logic      pop;

  assign pop = main_vld_q && out_ready_i;

  // A push only comes while the skid entry is empty.
  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (pop) begin
      if (skid_vld_q) begin
        main_d     = skid_q;
        skid_vld_d = 1'b0;
      end else if (push_i) begin
        main_d = push_data_i;
      end else begin
        main_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_vld_q) begin
        main_d     = push_data_i;
        main_vld_d = 1'b1;
      end else begin
        skid_d     = push_data_i;
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_vld_q;
  assign out_valid_o = main_vld_q;
  assign out_data_o  = main_q;

endmodule

`default_nettype wire

### sv/wav_header_chunk_parser_top.sv
// WAV header parser top level: input register, limit register, parse logic, result buffer.
//
// The input channel takes one file byte per word, with file_start marking byte zero
// of a new file. The parser checks the RIFF and WAVE signatures, walks the chunk list,
// keeps the fmt fields and gives one result word per file on the output channel,
// either when the data chunk size is complete or as soon as the file is known bad.
// Bytes before a file start and after the result are dropped without a result.
// The configuration channel writes the chunk search limit; it is always ready and
// should only be written while no byte is in flight.
// A result word is valid once the byte that completes it has passed from the input
// register through the parse logic into the result register; a full skid entry holds that byte back.
// Throughput: one byte per cycle while the skid entry is free; the parse state is updated
// once per byte, so bytes can follow each other back to back.
// A stalled receiver is absorbed by a skid entry behind the result register; input
// ready drops only when that entry and the input register are both occupied.
// Reset clears the parse state to waiting for a file start, empties both buffers and
// sets the search limit to 1792.
`timescale 1ns / 1ps
`default_nettype none

module wav_header_chunk_parser_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire wavhp_pkg::in_item_t           in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output wavhp_pkg::out_item_t               out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [wavhp_pkg::LIMIT_W-1:0] cfg_data_i
);
  import wavhp_pkg::*;

  logic               in_vld_q, in_vld_d;
  in_item_t           in_q;
  logic [LIMIT_W-1:0] limit_q;
  logic               skid_full;
  logic               advance;
  logic               res_valid;
  out_item_t          res;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_vld_q && !skid_full;
  assign in_ready_o  = !in_vld_q || !skid_full;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_valid_i && in_ready_o) in_vld_d = 1'b1;
    else if (advance)             in_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      limit_q  <= LIMIT_W'(LIMIT_RESET);
    end else begin
      in_vld_q <= in_vld_d;
      if (cfg_valid_i && cfg_ready_o) limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
  end

  wavhp_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .item_i         (in_q),
    .search_limit_i (limit_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  wavhp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### sv/wavhp_checker.sv
// Port-level checks of the WAV header parser, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module wavhp_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire wavhp_pkg::in_item_t           in_data_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire wavhp_pkg::out_item_t          out_data_o,
  input wire logic                          cfg_valid_i,
  input wire logic                          cfg_ready_o,
  input wire logic [wavhp_pkg::LIMIT_W-1:0] cfg_data_i
);
  import wavhp_pkg::*;

  logic unused_ok;
  assign unused_ok = &{in_valid_i, in_ready_o, in_data_i, cfg_valid_i, cfg_ready_o, cfg_data_i};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result word changed while stalled");

  // A valid layout code implies fmt fields that match it.
  a_layout_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.layout_code != LAYOUT_INVALID |->
      (out_data_o.sample_bits == 16'd16 || out_data_o.sample_bits == 16'd24) &&
      (out_data_o.channel_count == 16'd1 || out_data_o.channel_count == 16'd2))
    else $error("layout code disagrees with fmt fields");

  a_data_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.layout_code != LAYOUT_INVALID |->
      out_data_o.data_end >= END_W'(out_data_o.data_start))
    else $error("data end lies before data start");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.layout_code <= LAYOUT_INVALID)
    else $error("layout code out of range");

endmodule

bind wav_header_chunk_parser_top wavhp_checker u_wavhp_checker (.*);

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the WAV header chunk parser.
`timescale 1ns / 1ps

module tb;
  import wavhp_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int SEG_BYTES     = 60;
  localparam int FILE_CAP      = 2100;

  localparam logic [31:0] RIFF_TEXT = "RIFF";
  localparam logic [31:0] WAVE_TEXT = "WAVE";
  // Chunk IDs as they appear once four bytes are shifted in little-endian.
  localparam logic [31:0] ID_FMT    = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA   = 32'h6174_6164;
  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam int          FMT_BODY  = 16;

  // Offsets inside a chunk at which a field is complete.
  localparam int REL_ID_END    = 3;
  localparam int REL_SIZE_END  = 7;
  localparam int REL_TAG_END   = 9;
  localparam int REL_CHANS_END = 11;
  localparam int REL_RATE_END  = 15;
  localparam int REL_BITS_END  = 23;

  typedef enum logic [2:0] {P_IDLE, P_SIGNATURE, P_SEEK, P_IN_CHUNK, P_DONE} parse_phase_e;

  class wav_header_scoreboard;
    logic [LIMIT_W-1:0] limit;
    parse_phase_e       phase;
    int unsigned        offs;
    int unsigned        pos;
    logic [63:0]        target;
    logic [31:0]        shift_word;
    logic [31:0]        chunk_len;
    logic [31:0]        rate;
    logic [15:0]        chans;
    logic [15:0]        bits;
    bit                 fmt_found;
    bit                 id_match;
    out_item_t          verdicts_due[$];
    int                 errors;
    int                 checked;
    int                 predicted;
    int                 invalids;

    function new();
      limit     = LIMIT_W'(LIMIT_RESET);
      errors    = 0;
      checked   = 0;
      predicted = 0;
      invalids  = 0;
      restart();
    endfunction

    function void restart();
      phase      = P_IDLE;
      offs       = 0;
      pos        = 0;
      target     = '0;
      shift_word = '0;
      chunk_len  = '0;
      rate       = '0;
      chans      = '0;
      bits       = '0;
      fmt_found  = 1'b0;
      id_match   = 1'b0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] value);
      limit = value;
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    function void push_verdict(logic [2:0] code, logic [63:0] first, logic [63:0] last);
      out_item_t v;
      v.layout_code   = code;
      v.channel_count = chans;
      v.sample_bits   = bits;
      v.rate_hz       = rate;
      v.data_start    = first[START_W-1:0];
      v.data_end      = last[END_W-1:0];
      verdicts_due.push_back(v);
      phase = P_DONE;
      predicted++;
      if (code == LAYOUT_INVALID) invalids++;
    endfunction

    function void reject();
      push_verdict(LAYOUT_INVALID, '0, '0);
    endfunction

    // The next chunk header has to fit wholly inside the window.
    function void seek_to(logic [63:0] follow);
      if (follow + 64'd8 > 64'(WINDOW_BYTES)) begin
        reject();
      end else begin
        target = follow;
        phase  = P_SEEK;
      end
    endfunction

    function void chunk_byte(logic [7:0] b);
      int unsigned rel;
      logic [63:0] follow;
      logic [2:0]  code;
      rel        = offs - pos;
      shift_word = {b, shift_word[31:8]};
      follow     = 64'(pos) + 64'(chunk_len) + 64'd8;
      case (rel)
        REL_ID_END: begin
          id_match = shift_word == (fmt_found ? ID_DATA : ID_FMT);
          if (!id_match && pos > limit) reject();
        end
        REL_SIZE_END: begin
          chunk_len = shift_word;
          follow    = 64'(pos) + 64'(chunk_len) + 64'd8;
          if (!id_match) begin
            seek_to(follow);
          end else if (fmt_found) begin
            if (bits == 16 && chans == 1) code = LAYOUT_16_MONO;
            else if (bits == 16 && chans == 2) code = LAYOUT_16_STEREO;
            else if (bits == 24 && chans == 1) code = LAYOUT_24_MONO;
            else if (bits == 24 && chans == 2) code = LAYOUT_24_STEREO;
            else code = LAYOUT_INVALID;
            push_verdict(code, 64'(pos) + 64'd8, follow);
          end else if (chunk_len < FMT_BODY) begin
            reject();
          end
        end
        REL_TAG_END: begin
          if (shift_word[31:16] != FMT_PCM) reject();
        end
        REL_CHANS_END: chans = shift_word[31:16];
        REL_RATE_END:  rate  = shift_word;
        REL_BITS_END: begin
          bits      = shift_word[31:16];
          fmt_found = 1'b1;
          seek_to(follow);
        end
        default: ;
      endcase
    endfunction

    function void parse_byte(in_item_t it);
      if (it.file_start) begin
        restart();
        phase = P_SIGNATURE;
      end else if (phase == P_IDLE || phase == P_DONE) begin
        return;
      end
      if (phase == P_SIGNATURE) begin
        if (offs < 4) begin
          if (it.header_byte != RIFF_TEXT[8*(3-offs) +: 8]) reject();
        end else if (offs >= 8 && offs < 12) begin
          if (it.header_byte != WAVE_TEXT[8*(11-offs) +: 8]) reject();
          else if (offs == 11) seek_to(64'd12);
        end
      end else begin
        if (phase == P_SEEK && 64'(offs) == target) begin
          pos   = offs;
          phase = P_IN_CHUNK;
        end
        if (phase == P_IN_CHUNK) chunk_byte(it.header_byte);
      end
      if (offs < WINDOW_BYTES) offs++;
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (verdicts_due.size() == 0) begin
        report($sformatf("result %0h arrived with nothing expected", got));
        return;
      end
      want = verdicts_due.pop_front();
      checked++;
      if (got.layout_code !== want.layout_code)
        report($sformatf("layout_code %0d, expected %0d", got.layout_code, want.layout_code));
      if (got.channel_count !== want.channel_count)
        report($sformatf("channel_count %0d, expected %0d", got.channel_count,
                         want.channel_count));
      if (got.sample_bits !== want.sample_bits)
        report($sformatf("sample_bits %0d, expected %0d", got.sample_bits, want.sample_bits));
      if (got.rate_hz !== want.rate_hz)
        report($sformatf("rate_hz %0d, expected %0d", got.rate_hz, want.rate_hz));
      if (got.data_start !== want.data_start)
        report($sformatf("data_start %0d, expected %0d", got.data_start, want.data_start));
      if (got.data_end !== want.data_end)
        report($sformatf("data_end %0h, expected %0h", got.data_end, want.data_end));
    endtask
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  in_item_t           in_data_i   = '0;
  logic               out_ready_i = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic [LIMIT_W-1:0] cfg_data_i  = '0;
  logic               in_ready_o;
  logic               out_valid_o;
  out_item_t          out_data_o;
  logic               cfg_ready_o;

  wav_header_scoreboard sb = new();
  logic [7:0] file_bytes[$];
  int         idle_pct  = 26;
  int         stall_pct = 75;
  int         bytes_sent = 0;
  int         files_sent = 0;

  wav_header_chunk_parser_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  function automatic void put_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_text(logic [31:0] s);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(s[8*i +: 8]);
  endfunction

  function automatic void put_fill(int unsigned n);
    repeat (n) begin
      if (file_bytes.size() < FILE_CAP) file_bytes.push_back(8'($urandom));
    end
  endfunction

  // Layout: RIFF/WAVE header, optional early data chunk, fmt, optional second fmt,
  // unrelated chunks, data chunk, a few trailing bytes.
  function automatic void build_wav(int n_junk, logic [31:0] junk_len, logic [31:0] fmt_len,
                                    logic [15:0] fmt_tag, logic [15:0] chans,
                                    logic [15:0] bits, logic [31:0] rate,
                                    logic [31:0] data_len, bit odd_order);
    file_bytes.delete();
    put_text("RIFF");
    put_le($urandom, 4);
    put_text("WAVE");
    if (odd_order) begin
      put_text("data");
      put_le(32'd2, 4);
      put_fill(2);
    end
    put_text("fmt ");
    put_le(fmt_len, 4);
    put_le(32'(fmt_tag), 2);
    put_le(32'(chans), 2);
    put_le(rate, 4);
    put_le($urandom, 4);
    put_le($urandom, 2);
    put_le(32'(bits), 2);
    if (fmt_len > FMT_BODY && fmt_len < 64) put_fill(fmt_len - FMT_BODY);
    if (odd_order) begin
      put_text("fmt ");
      put_le(32'(FMT_BODY), 4);
      put_fill(FMT_BODY);
    end
    // Long chunks get no body, so the parser is left seeking past the end.
    repeat (n_junk) begin
      put_le($urandom, 4);
      put_le(junk_len, 4);
      if (junk_len < 64) put_fill(junk_len);
    end
    put_text("data");
    put_le(data_len, 4);
    put_fill($urandom_range(0, 2));
  endfunction

  function automatic logic [15:0] pick_of_two(logic [15:0] a, logic [15:0] b);
    int roll;
    roll = $urandom_range(99);
    if (roll < 45) return a;
    if (roll < 90) return b;
    return 16'($urandom);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit start);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i            = 1'b1;
    in_data_i.header_byte = b;
    in_data_i.file_start  = start;
    do @(posedge clk_i); while (!in_ready_o);
    sb.parse_byte(in_data_i);
    bytes_sent++;
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == 0);
    files_sent++;
  endtask

  // Holds the sender off until every expected result is out, then lets the
  // pipeline empty of bytes that produce no result.
  task automatic settle(input int extra);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_limit(value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    #15_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int               roll;
    int               seg_bytes;
    int               seg_results;
    logic [LIMIT_W-1:0] lim;
    logic [31:0]      data_len;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, under the search limit that reset leaves.
    repeat (4) send_byte(8'($urandom), 1'b0);
    build_wav(0, 0, 16, FMT_PCM, 1, 16, 32'd8000, 32'd0, 1'b0);
    send_file();
    build_wav(1, 0, 16, FMT_PCM, 2, 16, 32'd44100, 32'hFFFF_FFFF, 1'b0);
    send_file();
    build_wav(0, 0, 20, FMT_PCM, 1, 24, 32'hFFFF_FFFF, 32'd100, 1'b0);
    send_file();
    build_wav(2, 3, 18, FMT_PCM, 2, 24, 32'd0, $urandom, 1'b1);
    send_file();
    build_wav(0, 0, 16, FMT_PCM, 16'hFFFF, 16'd8, $urandom, $urandom, 1'b0);
    send_file();
    build_wav(0, 0, 16, 16'd3, 2, 16, $urandom, $urandom, 1'b0);
    send_file();
    build_wav(0, 0, 16, 16'hFFFF, 2, 16, $urandom, $urandom, 1'b0);
    send_file();
    build_wav(0, 0, 15, FMT_PCM, 2, 16, $urandom, $urandom, 1'b0);
    send_file();
    build_wav(0, 0, 0, FMT_PCM, 2, 16, $urandom, $urandom, 1'b0);
    send_file();
    file_bytes = '{8'hFF};
    send_file();
    file_bytes = '{8'h00, 8'h00};
    send_file();
    build_wav(0, 0, 16, FMT_PCM, 1, 16, $urandom, $urandom, 1'b0);
    file_bytes[10] ^= 8'h01;
    send_file();
    build_wav(1, 32'hFFFF_FFFF, 16, FMT_PCM, 1, 16, $urandom, $urandom, 1'b0);
    send_file();
    // A file cut short by the start of the next one.
    build_wav(0, 0, 16, FMT_PCM, 1, 16, $urandom, $urandom, 1'b0);
    file_bytes = file_bytes[0:19];
    send_file();
    // Next chunk header ending on the last window byte, then one byte too far.
    build_wav(1, 1996, 16, FMT_PCM, 2, 24, $urandom, $urandom, 1'b0);
    send_file();
    build_wav(1, 1997, 16, FMT_PCM, 2, 24, $urandom, $urandom, 1'b0);
    send_file();

    // Search limit at zero: only chunks found where sought survive.
    settle(SETTLE_CYCLES);
    write_limit('0);
    build_wav(1, 2, 16, FMT_PCM, 1, 16, $urandom, $urandom, 1'b0);
    send_file();
    build_wav(0, 0, 16, FMT_PCM, 2, 16, $urandom, $urandom, 1'b0);
    send_file();

    for (int seg = 0; seg < 6; seg++) begin
      settle(SETTLE_CYCLES);
      idle_pct  = (seg < 2) ? 26 : (seg < 4) ? 75 : 0;
      stall_pct = (seg < 2) ? 75 : (seg < 4) ? 26 : 0;
      case (seg)
        0: lim = '1;
        1: lim = LIMIT_W'($urandom_range(12, 60));
        2: lim = LIMIT_W'($urandom);
        3: lim = '0;
        4: lim = LIMIT_W'($urandom_range(12, 60));
        default: lim = LIMIT_W'(LIMIT_RESET);
      endcase
      write_limit(lim);
      seg_bytes   = bytes_sent;
      seg_results = sb.predicted;
      while (bytes_sent - seg_bytes < SEG_BYTES || sb.predicted - seg_results < 1) begin
        roll = $urandom_range(99);
        if (roll < 3) begin
          file_bytes.delete();
          repeat ($urandom_range(1, 16)) file_bytes.push_back(8'($urandom));
        end else begin
          case ($urandom_range(19))
            0:       data_len = '0;
            1, 2:    data_len = '1;
            3, 4, 5: data_len = $urandom_range(1, 64);
            default: data_len = $urandom;
          endcase
          build_wav($urandom_range(0, 2),
                    (roll < 5)  ? 32'($urandom_range(1200, 1990)) :
                    (roll < 10) ? $urandom : 32'($urandom_range(0, 6)),
                    ($urandom_range(9) == 0) ? 32'($urandom_range(0, 15)) :
                                               32'($urandom_range(16, 22)),
                    ($urandom_range(9) == 0) ? 16'($urandom) : FMT_PCM,
                    pick_of_two(1, 2), pick_of_two(16, 24), $urandom, data_len,
                    $urandom_range(6) == 0);
          if ($urandom_range(9) == 0)
            file_bytes[$urandom_range(file_bytes.size() - 1)] ^= 8'($urandom_range(1, 255));
          if ($urandom_range(12) == 0)
            file_bytes = file_bytes[0:$urandom_range(file_bytes.size() - 1)];
        end
        send_file();
        if ($urandom_range(19) == 0) begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
        end
        if ($urandom_range(9) == 0) settle(0);
      end
    end

    settle(4 * SETTLE_CYCLES);
    $display("Sent %0d header bytes in %0d files; %0d results checked, %0d of them invalid.",
             bytes_sent, files_sent, sb.checked, sb.invalids);
    $display("Search limit swept from 0 to 2047 under three idle and stall mixes.");
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
